/* rtl/core/kpsd_pkg.sv */
package kpsd_pkg;

   localparam int ROWS        = 4;
   localparam int COLS        = 3;
   localparam int MATRIX_W    = ROWS * COLS;
   localparam int CODE_W      = 4;
   localparam int BYTE_W      = 8;
   localparam int NUM_CODES   = 13;
   localparam int TICKS_W     = 8;
   localparam int MAP_LOW_W   = 64;
   localparam int MAP_HIGH_W  = 40;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 2;

   localparam logic [COLS-1:0]    COL_CLAMP     = 3'd3;
   localparam logic [TICKS_W-1:0] TICKS_RESET   = 8'd20;
   localparam logic [CODE_W-1:0]  CODE_NONE     = 4'd0;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE_TICKS = 2'd0,
      CSR_MAP_LOW        = 2'd1,
      CSR_MAP_HIGH       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [BYTE_W-1:0] data;
   } ring_ctl_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic              nonempty_next;
      logic [BYTE_W-1:0] head;
   } ring_stat_type;

endpackage

/* rtl/core/kpsd_if.sv */
interface kpsd_req_if;
   import kpsd_pkg::*;
   logic                valid;
   logic                ready;
   logic                op;
   logic [MATRIX_W-1:0] pressed_matrix;

   modport source (output valid, output op, output pressed_matrix, input ready);
   modport sink   (input valid, input op, input pressed_matrix, output ready);
endinterface

interface kpsd_rsp_if;
   import kpsd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] read_byte;
   logic              irq_pending;

   modport source (output valid, output read_byte, output irq_pending, input ready);
   modport sink   (input valid, input read_byte, input irq_pending, output ready);
endinterface

/* rtl/core/kpsd_code_enc.sv */
module kpsd_code_enc
   import kpsd_pkg::*;
(
   input  logic [MATRIX_W-1:0] matrix,
   output logic [CODE_W-1:0]   code
);

   logic [COLS-1:0] cols;

   // lowest pressed row wins
   always_comb begin
      code = CODE_NONE;
      cols = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         cols = matrix[r*COLS +: COLS];
         if (cols > COL_CLAMP) begin
            cols = COL_CLAMP;
         end
         if (cols != '0) begin
            code = CODE_W'(r * COLS) + CODE_W'(cols);
         end
      end
   end

endmodule

/* rtl/core/kpsd_ring.sv */
module kpsd_ring
   import kpsd_pkg::*;
#(
   parameter int RING_DEPTH = 16
)(
   input  logic          clock,
   input  logic          reset,
   input  ring_ctl_type  ctl,
   output ring_stat_type stat
);

   localparam int PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

   logic [BYTE_W-1:0] mem [RING_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_step, rd_step;
   logic [BYTE_W-1:0] head_ff;
   logic              do_push, do_pop;

   assign wr_step = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_step = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;

   assign stat.empty = (wr_ptr_ff == rd_ptr_ff);
   assign stat.full  = (wr_step == rd_ptr_ff);
   assign do_push    = ctl.push && !stat.full;
   assign do_pop     = ctl.pop && !stat.empty;

   assign wr_ptr_in = do_push ? wr_step : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_step : rd_ptr_ff;

   assign stat.nonempty_next = (wr_ptr_in != rd_ptr_in);
   assign stat.head          = head_ff;

   // head tracks mem[rd_ptr], write-first on a hit
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= ctl.data;
      end
      if (do_push && wr_ptr_ff == rd_ptr_in) begin
         head_ff <= ctl.data;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push && stat.full |=> $stable(wr_ptr_ff))
      else $error("ring write pointer moved on a full ring");

   a_push_pop_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.pop))
      else $error("ring push and pop in the same beat");

endmodule

/* rtl/core/keypad_scan_debounce_fifo_unit.sv */
// channel | dir | handshake         | payload
// req_bus | in  | valid/ready       | op, pressed_matrix
// rsp_bus | out | valid/ready       | read_byte, irq_pending
// csr_*   | in  | csr_we (no ready) | csr_index, csr_wdata
//
// One beat per cycle sustained while rsp is ready; a req beat passes the
// input register, then the result register, before its rsp beat.
// Ring head is held in a register fed by the ring memory read port.
// Synchronous active-high reset clears pointers, debounce state and maps.
// A stalled rsp holds the result; req stalls only while both stages are full
// and rsp is held.
module keypad_scan_debounce_fifo_unit
   import kpsd_pkg::*;
#(
   parameter int RING_DEPTH = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   kpsd_req_if.sink              req_bus,
   kpsd_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic                  in_valid_ff;
   logic                  in_op_ff;
   logic [MATRIX_W-1:0]   in_matrix_ff;
   logic                  out_valid_ff;
   logic [BYTE_W-1:0]     out_byte_ff, out_byte_in;
   logic                  out_irq_ff;

   logic [TICKS_W-1:0]    ticks_ff;
   logic [MAP_LOW_W-1:0]  map_low_ff;
   logic [MAP_HIGH_W-1:0] map_high_ff;

   logic [CODE_W-1:0]     last_code_ff, last_code_in;
   logic [TICKS_W-1:0]    count_ff, count_in;

   logic [CODE_W-1:0]     code;
   logic [BYTE_W-1:0]     map_tab [NUM_CODES];
   logic [BYTE_W-1:0]     code_byte;
   logic                  fire;
   logic                  req_beat;
   ring_ctl_type          ring_ctl;
   ring_stat_type         ring_stat;

   assign fire          = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || fire;
   assign req_beat      = req_bus.valid && req_bus.ready;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         map_tab[i] = map_low_ff[i*BYTE_W +: BYTE_W];
      end
      for (int i = 8; i < NUM_CODES; i++) begin
         map_tab[i] = map_high_ff[(i-8)*BYTE_W +: BYTE_W];
      end
   end

   kpsd_code_enc u_enc (
      .matrix (in_matrix_ff),
      .code   (code)
   );

   assign code_byte = (code < CODE_W'(NUM_CODES)) ? map_tab[code] : '0;

   always_comb begin
      ring_ctl     = '0;
      ring_ctl.data = code_byte;
      out_byte_in  = '0;
      last_code_in = last_code_ff;
      count_in     = count_ff;
      if (fire) begin
         case (op_type'(in_op_ff))
            OP_READ: begin
               if (ring_stat.empty) begin
                  out_byte_in = map_tab[0];
               end else begin
                  out_byte_in  = ring_stat.head;
                  ring_ctl.pop = 1'b1;
               end
            end
            OP_TICK: begin
               if (code != last_code_ff) begin
                  count_in     = ticks_ff;
                  last_code_in = code;
               end else if (count_ff != '0) begin
                  count_in      = count_ff - 1'b1;
                  ring_ctl.push = (count_ff == TICKS_W'(1)) && (code != CODE_NONE);
               end
            end
            default: ;
         endcase
      end
   end

   kpsd_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (ring_ctl),
      .stat  (ring_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_code_ff <= CODE_NONE;
         count_ff     <= '0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         last_code_ff <= last_code_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_op_ff     <= req_bus.op;
         in_matrix_ff <= req_bus.pressed_matrix;
      end
      if (fire) begin
         out_byte_ff <= out_byte_in;
         out_irq_ff  <= ring_stat.nonempty_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff    <= TICKS_RESET;
         map_low_ff  <= '0;
         map_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_TICKS: ticks_ff    <= csr_wdata[TICKS_W-1:0];
            CSR_MAP_LOW:        map_low_ff  <= csr_wdata[MAP_LOW_W-1:0];
            CSR_MAP_HIGH:       map_high_ff <= csr_wdata[MAP_HIGH_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.read_byte   = out_byte_ff;
   assign rsp_bus.irq_pending = out_irq_ff;

   a_ready_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> in_valid_ff && out_valid_ff && !rsp_bus.ready)
      else $error("req stalled without a blocked result");

   a_fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed beat lost before the result register");

   a_tick_result_zero: assert property (@(posedge clock) disable iff (reset)
      fire && in_op_ff == OP_TICK |=> out_byte_ff == '0)
      else $error("scan tick produced a non-zero byte");

endmodule

/* test/kpsd_key_checker.sv */
module kpsd_key_checker
   import kpsd_pkg::*;
#(
   parameter int RING_DEPTH = 16
)(
   input  logic                  clock,
   input  logic                  reset,
   kpsd_req_if                   req_bus,
   kpsd_rsp_if                   rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    awaiting,
   output int                    fail_count
);

   typedef struct packed {
      logic [BYTE_W-1:0] read_byte;
      logic              irq_pending;
   } key_result_type;

   logic [TICKS_W-1:0]              debounce_ticks;
   logic [MAP_HIGH_W+MAP_LOW_W-1:0] key_map;
   logic [BYTE_W-1:0]               key_ring [RING_DEPTH];
   int                              write_slot;
   int                              read_slot;
   logic [CODE_W-1:0]               last_code;
   logic [TICKS_W-1:0]              debounce_count;
   key_result_type                  key_results_q [$];

   function automatic int next_slot(input int slot);
      return (slot + 1 == RING_DEPTH) ? 0 : slot + 1;
   endfunction

   function automatic logic [CODE_W-1:0] key_code(input logic [MATRIX_W-1:0] matrix);
      logic [COLS-1:0] cols;
      int              row;
      for (row = 0; row < ROWS; row++) begin
         cols = matrix[COLS*row +: COLS];
         if (cols > COL_CLAMP) cols = COL_CLAMP;
         if (cols != '0) return CODE_W'(row * COLS + int'(cols));
      end
      return CODE_NONE;
   endfunction

   function automatic logic [BYTE_W-1:0] key_byte(input logic [CODE_W-1:0] code);
      return key_map[BYTE_W*code +: BYTE_W];
   endfunction

   // advances the keypad state by one beat and returns what the block should answer
   function automatic key_result_type scan_or_read(input op_type op,
                                                   input logic [MATRIX_W-1:0] matrix);
      key_result_type    res;
      logic [CODE_W-1:0] code;
      res.read_byte = '0;
      if (op == OP_READ) begin
         if (write_slot == read_slot) begin
            res.read_byte = key_byte(CODE_NONE);
         end else begin
            res.read_byte = key_ring[read_slot];
            read_slot = next_slot(read_slot);
         end
      end else begin
         code = key_code(matrix);
         if (code != last_code) begin
            debounce_count = debounce_ticks;
            last_code = code;
         end else if (debounce_count != '0) begin
            debounce_count = debounce_count - 1'b1;
            // full ring drops the byte
            if (debounce_count == '0 && code != CODE_NONE &&
                next_slot(write_slot) != read_slot) begin
               key_ring[write_slot] = key_byte(code);
               write_slot = next_slot(write_slot);
            end
         end
      end
      res.irq_pending = (write_slot != read_slot);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: key checker: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch_beats
      key_result_type got;
      key_result_type want;
      if (reset) begin
         debounce_ticks = TICKS_RESET;
         key_map = '0;
         write_slot = 0;
         read_slot = 0;
         last_code = CODE_NONE;
         debounce_count = '0;
         key_results_q.delete();
         fail_count = 0;
         awaiting <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE_TICKS: debounce_ticks = csr_wdata[TICKS_W-1:0];
               CSR_MAP_LOW:        key_map[MAP_LOW_W-1:0] = csr_wdata[MAP_LOW_W-1:0];
               CSR_MAP_HIGH:       key_map[MAP_LOW_W +: MAP_HIGH_W] = csr_wdata[MAP_HIGH_W-1:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.read_byte = rsp_bus.read_byte;
            got.irq_pending = rsp_bus.irq_pending;
            if (key_results_q.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp beat, read_byte %02h irq %0b",
                                         got.read_byte, got.irq_pending));
            end else begin
               want = key_results_q.pop_front();
               if (got.read_byte !== want.read_byte)
                  report_mismatch($sformatf("read_byte %02h, expected %02h",
                                            got.read_byte, want.read_byte));
               if (got.irq_pending !== want.irq_pending)
                  report_mismatch($sformatf("irq_pending %0b, expected %0b",
                                            got.irq_pending, want.irq_pending));
            end
         end
         if (req_bus.valid && req_bus.ready)
            key_results_q.push_back(scan_or_read(op_type'(req_bus.op), req_bus.pressed_matrix));
         awaiting <= key_results_q.size();
      end
   end

endmodule

/* test/tb_top.sv */
module tb_top;
   import kpsd_pkg::*;

   localparam int RING_DEPTH      = 16;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    awaiting;
   int                    fail_count;
   int                    beats_sent;
   int                    cycle_count;
   int                    send_idle_pct;
   int                    recv_idle_pct;
   logic [TICKS_W-1:0]    debounce_now;
   bit                    hold_off_rsp;

   kpsd_req_if req_bus();
   kpsd_rsp_if rsp_bus();

   keypad_scan_debounce_fifo_unit #(.RING_DEPTH(RING_DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   kpsd_key_checker #(.RING_DEPTH(RING_DEPTH)) i_key_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .awaiting   (awaiting),
      .fail_count (fail_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin : rsp_drive
      int held;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_rsp) begin
            rsp_bus.ready <= 1'b0;
            for (held = 0; held < RSP_HOLD_CYCLES; held++) @(posedge clock);
            hold_off_rsp = 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_beat(input op_type op, input logic [MATRIX_W-1:0] matrix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= op;
      req_bus.pressed_matrix <= matrix;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // upper bits beyond each register's width are random and must be ignored
   task automatic load_settings(input logic [TICKS_W-1:0] ticks,
                                input logic [MAP_LOW_W-1:0] map_low,
                                input logic [MAP_HIGH_W-1:0] map_high);
      wait_drain();
      write_csr(CSR_UNUSED, {$urandom, $urandom});
      write_csr(CSR_DEBOUNCE_TICKS, {$urandom, 24'($urandom), ticks});
      write_csr(CSR_MAP_LOW, map_low);
      write_csr(CSR_MAP_HIGH, {24'($urandom), map_high});
      csr_we <= 1'b0;
      debounce_now = ticks;
   endtask

   // one key held for a while, reads mixed in, some contact bounce on short settings
   task automatic key_sequence(input int read_pct);
      logic [MATRIX_W-1:0] matrix;
      int                  hold;
      int                  n;
      int                  row;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            row = $urandom_range(ROWS - 1);
            matrix = MATRIX_W'($urandom);
            matrix = matrix & ~MATRIX_W'((1 << (COLS * row)) - 1);
            matrix[COLS*row +: COLS] = COLS'($urandom_range(1, 7));
         end
         5, 6: matrix = MATRIX_W'($urandom);
         7: matrix = '0;
         default: matrix = MATRIX_W'(1 << $urandom_range(MATRIX_W - 1));
      endcase
      if (debounce_now == '0)
         hold = $urandom_range(1, 6);
      else if ($urandom_range(9) < 7)
         hold = int'(debounce_now) + 1 + $urandom_range(0, 2);
      else
         hold = $urandom_range(1, int'(debounce_now) + 1);
      for (n = 0; n < hold; n++) begin
         if ($urandom_range(99) < read_pct)
            send_beat(OP_READ, MATRIX_W'($urandom));
         if (debounce_now < 8'd16 && $urandom_range(19) == 0)
            send_beat(OP_TICK, MATRIX_W'($urandom));
         else
            send_beat(OP_TICK, matrix);
      end
   endtask

   task automatic run_phase(input logic [TICKS_W-1:0] ticks,
                            input logic [MAP_LOW_W-1:0] map_low,
                            input logic [MAP_HIGH_W-1:0] map_high,
                            input int read_pct, input int send_idle, input int recv_idle,
                            input int beats, input bit squeeze);
      int  target;
      bit  drained;
      load_settings(ticks, map_low, map_high);
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      target = beats_sent + beats;
      drained = 1'b0;
      if (squeeze) hold_off_rsp = 1'b1;
      while (beats_sent < target) begin
         if (squeeze && !drained && beats_sent > target - beats / 2) begin
            wait_drain();
            drained = 1'b1;
         end
         key_sequence(read_pct);
      end
   endtask

   initial begin : stimulus
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.op = OP_TICK;
      req_bus.pressed_matrix = '0;
      beats_sent = 0;
      send_idle_pct = 13;
      recv_idle_pct = 76;
      debounce_now = TICKS_RESET;
      hold_off_rsp = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(OP_READ, '0);
      load_settings(8'd1, 64'h8F7E_6D5C_4B3A_2918, 40'hF0_E1D2_C3B4);
      send_beat(OP_READ, 12'hFFF);
      send_beat(OP_TICK, 12'h000);
      repeat (3) send_beat(OP_TICK, 12'hFFF);
      repeat (2) send_beat(OP_TICK, 12'h000);
      repeat (2) send_beat(OP_TICK, 12'h200);
      repeat (2) send_beat(OP_TICK, 12'hE00);
      repeat (2) send_beat(OP_TICK, 12'h040);
      repeat (2) send_beat(OP_TICK, 12'hFFA);
      repeat (6) send_beat(OP_READ, 12'h000);

      run_phase(8'd1, {$urandom, $urandom}, {8'($urandom), $urandom}, 30, 13, 76, 260, 1'b0);
      run_phase(8'd2, {$urandom, $urandom}, {8'($urandom), $urandom}, 3, 13, 76, 200, 1'b1);
      run_phase(8'd0, {$urandom, $urandom}, {8'($urandom), $urandom}, 20, 76, 13, 120, 1'b0);
      run_phase(8'd3, {$urandom, $urandom}, {8'($urandom), $urandom}, 50, 76, 13, 260, 1'b0);
      run_phase(8'd255, '1, '1, 2, 0, 0, 60, 1'b0);
      run_phase(8'($urandom_range(4, 9)), '0, '0, 25, 0, 0, 200, 1'b0);

      wait_drain();
      if (fail_count == 0 && awaiting == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
